>>> src/prc_pkg.sv
`default_nettype none
package prc_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int AF = 16;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd5;

    localparam logic [16:0] ALPHA_ONE = 17'h10000;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_PROP,
        ST_DIFF,
        ST_DIV,
        ST_GAP,
        ST_FILT,
        ST_DERIV,
        ST_SUM,
        ST_IMUL1,
        ST_IMUL2,
        ST_IACC,
        ST_DONE
    } state_t;

    // saturate a 34-bit signed value to 32 bits
    function automatic logic signed [DW-1:0] sat34(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        begin
            hi = 34'sh0_7FFF_FFFF;
            lo = -34'sh0_8000_0000;
            if (v > hi)
                sat34 = 32'sh7FFF_FFFF;
            else if (v < lo)
                sat34 = 32'sh8000_0000;
            else
                sat34 = v[DW-1:0];
        end
    endfunction

endpackage
`default_nettype wire

>>> src/prc_mul.sv
`default_nettype none
// Signed-magnitude 32x32 fixed-point multiply, one product per cycle,
// registered result; truncated toward zero and saturated to 32 bits.
module prc_mul (
    input  wire logic                clk,
    input  wire logic                start,
    input  wire logic signed [32:0]  a,
    input  wire logic signed [32:0]  b,
    input  wire logic [4:0]          shift,
    output logic signed [31:0]       prod
);
    import prc_pkg::*;

    logic [31:0] ma;
    logic [31:0] mb;
    logic        neg;
    logic [63:0] full;
    logic [63:0] sh;
    logic [32:0] cap;
    logic [31:0] v;
    logic signed [31:0] prod_next;
    logic signed [31:0] prod_reg;

    // take magnitudes, multiply, shift, then saturate and restore the sign
    always_comb
    begin
        ma = a[32] ? 32'(-a) : a[31:0];
        mb = b[32] ? 32'(-b) : b[31:0];
        neg = a[32] ^ b[32];
        full = ma * mb;
        sh = full >> shift;
        cap = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        v = (sh > 64'(cap)) ? cap[31:0] : sh[31:0];
        prod_next = neg ? -$signed(v) : $signed(v);
    end

    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

>>> src/prc_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle: (mag << 16) / d,
// 48 numerator bits; quotient saturates into a signed 32-bit result.
module prc_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [31:0]        num_mag,
    input  wire logic               neg,
    input  wire logic [31:0]        den,
    output logic                    busy,
    output logic signed [31:0]      quot
);
    import prc_pkg::*;

    logic [47:0] num_reg, num_next;
    logic [47:0] q_reg, q_next;
    logic [32:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [32:0] trial;
    logic [32:0] cap;
    logic [31:0] v;

    // shift one bit, subtract if it fits
    always_comb
    begin
        num_next = num_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        trial = {rem_reg[31:0], num_reg[47]};
        if (start)
        begin
            num_next = {num_mag, 16'h0};
            q_next = '0;
            rem_next = '0;
            cnt_next = 6'd48;
            neg_next = neg;
        end
        else if (cnt_reg != 6'd0)
        begin
            num_next = {num_reg[46:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (trial >= {1'b0, den})
            begin
                rem_next = trial - {1'b0, den};
                q_next = {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next = {q_reg[46:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        q_reg <= q_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign busy = (cnt_reg != 6'd0);

    always_comb
    begin
        cap = neg_reg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        v = (q_reg > 48'(cap)) ? cap[31:0] : q_reg[31:0];
        quot = neg_reg ? -$signed(v) : $signed(v);
    end
endmodule
`default_nettype wire

>>> src/pid_rate_controller.sv
`default_nettype none
// PID rate controller, signed Q16.16. An update passes through the
// 48-step serial divider and a single shared multiplier that forms the
// proportional, filter, derivative and integral products in turn; the
// divider, filter and derivative steps are skipped with a zero time
// step or no earlier sample, and a clear zeroes the state and goes
// straight to the result. The block takes one item at a time; the result
// register holds the beat until it is taken.
module pid_rate_controller (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               op,
    input  wire logic signed [31:0] target_rate,
    input  wire logic signed [31:0] measured_rate,
    input  wire logic [31:0]        step_time,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      drive,
    output logic                    clipped,
    output logic signed [31:0]      rate_error,
    output logic signed [31:0]      prop_term,
    output logic signed [31:0]      deriv_term,
    output logic signed [33:0]      raw_drive,
    output logic signed [31:0]      integ_value
);
    import prc_pkg::*;

    localparam logic [4:0] FSH = 5'(FB);
    localparam logic [4:0] ASH = 5'(AF);

    logic [31:0] kp_reg, ki_reg, kd_reg;
    logic [16:0] alpha_reg;
    logic [30:0] lim_reg, ilim_reg;

    state_t state_reg, state_next;

    logic signed [31:0] integ_reg, integ_next;
    logic signed [31:0] filt_reg, filt_next;
    logic signed [31:0] last_reg, last_next;
    logic               have_reg, have_next;
    logic signed [31:0] mr_reg, tr_reg;
    logic [31:0]        dt_reg;
    logic signed [31:0] err_reg, err_next;
    logic signed [31:0] prop_reg, prop_next;
    logic signed [31:0] deriv_reg, deriv_next;
    logic signed [31:0] tmp_reg, tmp_next;
    logic signed [33:0] raw_reg, raw_next;
    logic signed [31:0] drv_reg, drv_next;
    logic               clip_reg, clip_next;
    logic               ov_reg, ov_next;

    logic               mul_start;
    logic signed [32:0] mul_a, mul_b;
    logic [4:0]         mul_sh;
    logic signed [31:0] mul_p;

    logic               div_start, div_busy;
    logic [31:0]        div_mag;
    logic               div_neg;
    logic signed [31:0] div_q;

    logic signed [33:0] lim_s;
    logic signed [31:0] diff;
    logic [16:0]        alpha_c;
    logic signed [31:0] ilim_s;

    prc_mul u_mul (
        .clk   (clk),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .shift (mul_sh),
        .prod  (mul_p)
    );

    prc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (div_mag),
        .neg     (div_neg),
        .den     (dt_reg),
        .busy    (div_busy),
        .quot    (div_q)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= '0;
            ki_reg <= '0;
            kd_reg <= '0;
            alpha_reg <= '0;
            lim_reg <= '0;
            ilim_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:    kp_reg <= cfg_data;
                REG_INTEG_GAIN:   ki_reg <= cfg_data;
                REG_DERIV_GAIN:   kd_reg <= cfg_data;
                REG_FILTER_ALPHA: alpha_reg <= cfg_data[16:0];
                REG_DRIVE_LIMIT:  lim_reg <= cfg_data[30:0];
                REG_INTEG_LIMIT:  ilim_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign lim_s = {3'b000, lim_reg};
    assign ilim_s = {1'b0, ilim_reg};
    assign alpha_c = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign diff = sat34(34'(mr_reg) - 34'(last_reg));
    assign in_ready = (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = op ? ST_DONE : ST_ERR;
            ST_ERR:   state_next = ST_PROP;
            ST_PROP:  state_next = (dt_reg != 0 && have_reg) ? ST_DIFF : ST_SUM;
            ST_DIFF:  state_next = ST_DIV;
            ST_DIV:   if (!div_busy) state_next = ST_GAP;
            ST_GAP:   state_next = ST_FILT;
            ST_FILT:  state_next = ST_DERIV;
            ST_DERIV: state_next = ST_SUM;
            ST_SUM:   state_next = ST_IMUL1;
            ST_IMUL1: state_next = ST_IMUL2;
            ST_IMUL2: state_next = ST_IACC;
            ST_IACC:  state_next = ST_DONE;
            ST_DONE:  if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        integ_next = integ_reg;
        filt_next = filt_reg;
        last_next = last_reg;
        have_next = have_reg;
        err_next = err_reg;
        prop_next = prop_reg;
        deriv_next = deriv_reg;
        tmp_next = tmp_reg;
        raw_next = raw_reg;
        drv_next = drv_reg;
        clip_next = clip_reg;
        ov_next = ov_reg;
        mul_start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        mul_sh = FSH;
        div_start = 1'b0;
        div_mag = diff[31] ? 32'(-34'(diff)) : diff;
        div_neg = diff[31];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && op)
                begin
                    integ_next = '0;
                    filt_next = '0;
                    last_next = '0;
                    have_next = 1'b0;
                    err_next = '0;
                    prop_next = '0;
                    deriv_next = '0;
                    raw_next = '0;
                    drv_next = '0;
                    clip_next = 1'b0;
                end
                else if (in_valid)
                    deriv_next = '0;
            end
            ST_ERR:
            begin
                err_next = sat34(34'(tr_reg) - 34'(mr_reg));
                mul_start = 1'b1;
                mul_a = {1'b0, kp_reg};
                mul_b = 33'(sat34(34'(tr_reg) - 34'(mr_reg)));
            end
            ST_PROP: prop_next = mul_p;
            ST_DIFF: div_start = 1'b1;
            ST_DIV:  ;
            ST_GAP:
            begin
                mul_start = 1'b1;
                mul_a = {16'h0, alpha_c};
                mul_b = 33'(sat34(34'(div_q) - 34'(filt_reg)));
                mul_sh = ASH;
            end
            ST_FILT:
            begin
                filt_next = sat34(34'(filt_reg) + 34'(mul_p));
                mul_start = 1'b1;
                mul_a = {1'b0, kd_reg};
                mul_b = 33'(sat34(34'(filt_reg) + 34'(mul_p)));
            end
            ST_DERIV: deriv_next = sat34(-34'(mul_p));
            ST_SUM:
            begin
                raw_next = 34'(prop_reg) + 34'(integ_reg) + 34'(deriv_reg);
                mul_start = 1'b1;
                mul_a = 33'(err_reg);
                mul_b = {1'b0, dt_reg};
            end
            ST_IMUL1:
            begin
                if (raw_reg > lim_s)
                    drv_next = lim_s[31:0];
                else if (raw_reg < -lim_s)
                    drv_next = 32'(-lim_s);
                else
                    drv_next = raw_reg[31:0];
                clip_next = (raw_reg > lim_s) || (raw_reg < -lim_s);
                mul_start = 1'b1;
                mul_a = 33'(mul_p);
                mul_b = {1'b0, ki_reg};
            end
            ST_IMUL2:
            begin
                ov_next = (34'(drv_reg) >= lim_s && err_reg > 0)
                       || (34'(drv_reg) <= -lim_s && err_reg < 0);
            end
            ST_IACC:
            begin
                if (dt_reg != 0 && ki_reg != 0 && !ov_reg)
                begin
                    tmp_next = sat34(34'(integ_reg) + 34'(mul_p));
                    if (tmp_next > ilim_s)
                        integ_next = ilim_s;
                    else if (tmp_next < -ilim_s)
                        integ_next = -ilim_s;
                    else
                        integ_next = tmp_next;
                end
                last_next = mr_reg;
                have_next = 1'b1;
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            integ_reg <= '0;
            filt_reg <= '0;
            last_reg <= '0;
            have_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            integ_reg <= integ_next;
            filt_reg <= filt_next;
            last_reg <= last_next;
            have_reg <= have_next;
        end
    end

    // hold item and working values
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tr_reg <= target_rate;
            mr_reg <= measured_rate;
            dt_reg <= step_time;
        end
        err_reg <= err_next;
        prop_reg <= prop_next;
        deriv_reg <= deriv_next;
        tmp_reg <= tmp_next;
        raw_reg <= raw_next;
        drv_reg <= drv_next;
        clip_reg <= clip_next;
        ov_reg <= ov_next;
    end

    assign out_valid = (state_reg == ST_DONE);
    assign drive = drv_reg;
    assign clipped = clip_reg;
    assign rate_error = err_reg;
    assign prop_term = prop_reg;
    assign deriv_term = deriv_reg;
    assign raw_drive = raw_reg;
    assign integ_value = integ_reg;

    // integrator lands inside its clamp after an integration step
    a_integ_lim: assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg == ST_IACC && dt_reg != 0 && ki_reg != 0 && !ov_reg)
        |-> (integ_reg <= ilim_s) && (integ_reg >= -ilim_s))
        else $error("integrator beyond limit");
    // never ready while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready during result");
    // result beat holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive))
        else $error("result dropped");
endmodule
`default_nettype wire
